[hw/rtl/stab_pkg.sv]
// Shared constants, payload structs and control types for the stability detector.
// Depends on nothing; every other file of the block imports it.
package stab_pkg;

   // Window and sample geometry.
   localparam int MAX_WINDOW    = 16;
   localparam int SAMPLE_BITS   = 12;
   localparam int NUM_CH        = 3;
   localparam int PTR_BITS      = $clog2(MAX_WINDOW);
   localparam int EFF_BITS      = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS      = 16;
   localparam int REM_BITS      = PTR_BITS;

   // The divider retires two quotient bits per cycle.
   localparam int BITS_PER_STEP = 2;
   localparam int DIV_STEPS     = SUM_BITS / BITS_PER_STEP;
   localparam int STEP_CNT_BITS = $clog2(DIV_STEPS);

   // Register file geometry and register indexes.
   localparam int LEN_BITS       = 5;
   localparam int THR_BITS       = 8;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LEN = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD  = 4'd1;

   localparam logic [LEN_BITS-1:0] WINDOW_LEN_RESET = 5'd10;
   localparam logic [THR_BITS-1:0] THRESHOLD_RESET  = 8'd4;

   typedef struct packed {
      logic [11:0] nh3_reading;
      logic [11:0] red_reading;
      logic [11:0] ox_reading;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] nh3_average;
      logic [11:0] red_average;
      logic [11:0] ox_average;
      logic        nh3_settled;
      logic        red_settled;
      logic        ox_settled;
      logic        all_settled;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DELIVER
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic step;
      logic load;
   } dp_cmd_type;

endpackage

[hw/rtl/stab_div.sv]
// Iterative restoring divider: window sum by window length, two bits a cycle while stepping.
// Depends on stab_pkg for the sum and remainder widths.
module stab_div import stab_pkg::*; (
   input  logic                clock,
   input  logic                start,
   input  logic                step,
   input  logic [SUM_BITS-1:0] dividend,
   input  logic [EFF_BITS-1:0] divisor,
   output logic [SUM_BITS-1:0] quotient
);

   logic [SUM_BITS-1:0] shift_ff, shift_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;

   // The shift register takes dividend bits out at the top and quotient bits in at the bottom.
   always_comb begin
      logic [REM_BITS:0] trial;
      logic [REM_BITS:0] dvs;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      trial    = '0;
      dvs      = (REM_BITS + 1)'(divisor);
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
      end else if (step) begin
         for (int i = 0; i < BITS_PER_STEP; i++) begin
            trial    = {rem_in, shift_in[SUM_BITS-1]};
            shift_in = {shift_in[SUM_BITS-2:0], 1'b0};
            if (trial >= dvs) begin
               trial       = trial - dvs;
               shift_in[0] = 1'b1;
            end
            rem_in = trial[REM_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign quotient = shift_ff;

endmodule

[hw/rtl/stab_ctrl.sv]
// Controller state machine: request handshake, divider sequencing and result valid.
// Depends on stab_pkg for the state enum and the command struct.
module stab_ctrl import stab_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   ctrl_state_type             state_ff, state_in;
   logic [STEP_CNT_BITS-1:0]   count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;

      // A result taken by the receiver frees the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               count_in   = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            count_in = count_ff + STEP_CNT_BITS'(1);
            if (count_ff == STEP_CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            // Wait until the output register is empty or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/stab_dp.sv]
// Datapath: configuration registers, circular windows, running sums, dividers and result register.
// Depends on stab_pkg and instantiates stab_div once for each channel.
module stab_dp import stab_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  dp_cmd_type                cmd,
   input  req_payload_type           req_payload,
   output rsp_payload_type           rsp_payload
);

   logic [LEN_BITS-1:0]    window_len_ff;
   logic [THR_BITS-1:0]    threshold_ff;
   logic [PTR_BITS-1:0]    ptr_ff;
   logic [MAX_WINDOW-1:0]  row_valid_ff;
   logic [SUM_BITS-1:0]    sum_ff [NUM_CH];
   logic [SAMPLE_BITS-1:0] win_ff [NUM_CH][MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] sample_ff [NUM_CH];
   rsp_payload_type        rsp_ff;

   logic [EFF_BITS-1:0]    eff_len;
   logic [PTR_BITS-1:0]    cur_ptr;
   logic [PTR_BITS-1:0]    ptr_in;
   logic [SAMPLE_BITS-1:0] reading [NUM_CH];
   logic [SAMPLE_BITS-1:0] old_entry [NUM_CH];
   logic [SUM_BITS-1:0]    sum_in [NUM_CH];
   logic [SUM_BITS-1:0]    quot [NUM_CH];
   logic [NUM_CH-1:0]      settled;
   logic                   clear_windows;

   assign clear_windows = csr_write && (csr_index == CSR_WINDOW_LEN);

   assign reading[0] = req_payload.nh3_reading;
   assign reading[1] = req_payload.red_reading;
   assign reading[2] = req_payload.ox_reading;

   // A zero length counts as one entry, a length past the window saturates.
   always_comb begin
      if (window_len_ff == '0) begin
         eff_len = EFF_BITS'(1);
      end else if (window_len_ff > LEN_BITS'(MAX_WINDOW)) begin
         eff_len = EFF_BITS'(MAX_WINDOW);
      end else begin
         eff_len = EFF_BITS'(window_len_ff);
      end
   end

   // Write slot for this request and the pointer after it.
   always_comb begin
      logic [EFF_BITS-1:0] nxt;
      if (EFF_BITS'(ptr_ff) >= eff_len) begin
         cur_ptr = '0;
      end else begin
         cur_ptr = ptr_ff;
      end
      nxt = EFF_BITS'(cur_ptr) + EFF_BITS'(1);
      if (nxt >= eff_len) begin
         ptr_in = '0;
      end else begin
         ptr_in = nxt[PTR_BITS-1:0];
      end
   end

   // Running sums: add the new reading, drop the one it overwrites.
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         old_entry[c] = row_valid_ff[cur_ptr] ? win_ff[c][cur_ptr] : '0;
         sum_in[c]    = sum_ff[c] + SUM_BITS'(reading[c]) - SUM_BITS'(old_entry[c]);
      end
   end

   // Control-like state: registers, valid rows, sums and pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RESET;
         threshold_ff  <= THRESHOLD_RESET;
         ptr_ff        <= '0;
         row_valid_ff  <= '0;
         for (int c = 0; c < NUM_CH; c++) begin
            sum_ff[c] <= '0;
         end
      end else if (csr_write) begin
         if (csr_index == CSR_WINDOW_LEN) begin
            window_len_ff <= csr_wdata[LEN_BITS-1:0];
         end
         if (csr_index == CSR_THRESHOLD) begin
            threshold_ff <= csr_wdata[THR_BITS-1:0];
         end
         if (clear_windows) begin
            ptr_ff       <= '0;
            row_valid_ff <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
               sum_ff[c] <= '0;
            end
         end
      end else if (cmd.accept) begin
         ptr_ff                <= ptr_in;
         row_valid_ff[cur_ptr] <= 1'b1;
         for (int c = 0; c < NUM_CH; c++) begin
            sum_ff[c] <= sum_in[c];
         end
      end
   end

   // Window entries and the latched readings carry no reset.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         for (int c = 0; c < NUM_CH; c++) begin
            win_ff[c][cur_ptr] <= reading[c];
            sample_ff[c]       <= reading[c];
         end
      end
   end

   // One divider per channel, all started together.
   for (genvar g = 0; g < NUM_CH; g++) begin : g_div
      stab_div u_div (
         .clock    (clock),
         .start    (cmd.accept),
         .step     (cmd.step),
         .dividend (sum_in[g]),
         .divisor  (eff_len),
         .quotient (quot[g])
      );
   end

   // Deviation of each reading from its average against the threshold.
   always_comb begin
      logic [SUM_BITS-1:0] cur;
      logic [SUM_BITS-1:0] dev;
      for (int c = 0; c < NUM_CH; c++) begin
         cur        = SUM_BITS'(sample_ff[c]);
         dev        = (quot[c] >= cur) ? (quot[c] - cur) : (cur - quot[c]);
         settled[c] = (dev < SUM_BITS'(threshold_ff));
      end
   end

   // Output register, loaded once the receiver side is free.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.nh3_average <= quot[0][11:0];
         rsp_ff.red_average <= quot[1][11:0];
         rsp_ff.ox_average  <= quot[2][11:0];
         rsp_ff.nh3_settled <= settled[0];
         rsp_ff.red_settled <= settled[1];
         rsp_ff.ox_settled  <= settled[2];
         rsp_ff.all_settled <= &settled;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

[hw/rtl/three_channel_stability_detector_top.sv]
// Three-channel stability detector: moving-average windows with a settling test.
// Each request carries three 12-bit readings and yields one response with the three
// window averages, three per-channel settled flags and an all-settled flag.
// Channels: req_valid/req_ready/req_payload in, rsp_valid/rsp_ready/rsp_payload out,
// and csr_valid/csr_ready/csr_index/csr_wdata for register writes (0 window length,
// 1 threshold; other indexes are ignored). csr_ready is always high.
// Each request passes an accept, the division in the per-channel radix-4 dividers
// (two quotient bits per cycle over the 16-bit sum) and a load of the output
// register once that register is free; the response is valid after the load.
// One request is processed at a time; a new request may be accepted while the
// previous response still waits in the output register.
// When the receiver stalls, the response holds and the next finished result waits
// in the datapath until the output register frees.
// Reset clears the windows, sums and pointer and sets window length 10, threshold 4.
// Writing the window length clears the windows, sums and pointer likewise.
// Depends on stab_pkg, stab_ctrl, stab_dp and stab_div.
module three_channel_stability_detector_top import stab_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   dp_cmd_type cmd;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   stab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   stab_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

[hw/rtl/stab_checker.sv]
// Port-level checker for the stability detector, bound to the top level.
// Depends on stab_pkg for the payload types.
module stab_checker import stab_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input req_payload_type           req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rsp_payload_type           rsp_payload
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // A stalled request holds its value.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("request changed while stalled");

   // The all-settled flag agrees with the three channel flags.
   a_all_settled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.all_settled == (rsp_payload.nh3_settled &&
         rsp_payload.red_settled && rsp_payload.ox_settled))
      else $error("all-settled flag inconsistent");

   // One request at a time: the block is busy right after accepting one.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind three_channel_stability_detector_top stab_checker u_stab_checker (.*);

[tb/three_channel_stability_detector_top_tb.sv]
// Self-checking testbench for the three-channel stability detector.
// Predicts averages and settled flags per request and checks every response in order.
// Depends on stab_pkg and three_channel_stability_detector_top.
module three_channel_stability_detector_top_tb;
   import stab_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int MAX_REPORTS   = 10;
   localparam int PHASE_ITEMS   = 40;
   localparam int RANDOM_PHASES = 12;
   localparam int LONG_HOLD     = 200;

   // Register indexes outside the implemented set.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LOW  = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_HIGH = 4'd15;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_payload_type           req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_payload_type           rsp_payload;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // Model state: windows, running sums, pointer and the two registers.
   logic [11:0]         window_mem [NUM_CH][MAX_WINDOW];
   logic [15:0]         window_sum [NUM_CH];
   int                  write_ptr;
   logic [LEN_BITS-1:0] window_len_reg;
   logic [THR_BITS-1:0] threshold_reg;

   rsp_payload_type predicted_averages_q [$];
   int              mismatches;
   int              cycle_count;
   bit              steady_flow;
   int              long_hold;
   int              level [NUM_CH];
   int              spread;

   three_channel_stability_detector_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Empties all windows, sums and the pointer.
   task automatic clear_windows();
      for (int c = 0; c < NUM_CH; c++) begin
         window_sum[c] = '0;
         for (int i = 0; i < MAX_WINDOW; i++) window_mem[c][i] = '0;
      end
      write_ptr = 0;
   endtask

   // Updates the windows for one request and returns the response it should produce.
   function automatic rsp_payload_type predict_averages(req_payload_type p);
      rsp_payload_type r;
      int len;
      int ptr;
      int cur [NUM_CH];
      int avg [NUM_CH];
      bit ok [NUM_CH];
      int sum_v;
      int dev;
      cur[0] = p.nh3_reading;
      cur[1] = p.red_reading;
      cur[2] = p.ox_reading;
      len = (window_len_reg == 0) ? 1 :
            (window_len_reg > MAX_WINDOW) ? MAX_WINDOW : int'(window_len_reg);
      ptr = (write_ptr >= len) ? 0 : write_ptr;
      for (int c = 0; c < NUM_CH; c++) begin
         window_sum[c] = 16'(int'(window_sum[c]) + cur[c] - int'(window_mem[c][ptr]));
         window_mem[c][ptr] = 12'(cur[c]);
         sum_v = window_sum[c];
         avg[c] = sum_v / len;
         dev = (avg[c] >= cur[c]) ? avg[c] - cur[c] : cur[c] - avg[c];
         ok[c] = (dev < int'(threshold_reg));
      end
      ptr++;
      write_ptr = (ptr >= len) ? 0 : ptr;
      r.nh3_average = 12'(avg[0]);
      r.red_average = 12'(avg[1]);
      r.ox_average  = 12'(avg[2]);
      r.nh3_settled = ok[0];
      r.red_settled = ok[1];
      r.ox_settled  = ok[2];
      r.all_settled = ok[0] & ok[1] & ok[2];
      return r;
   endfunction

   // Draws one reading per channel: mostly noise around a slowly moving level,
   // now and then a jump, a full-range value or an extreme.
   function automatic req_payload_type draw_readings();
      req_payload_type p;
      int v [NUM_CH];
      int roll;
      for (int c = 0; c < NUM_CH; c++) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) level[c] = $urandom_range(0, 4095);
         if (roll < 4) begin
            v[c] = ($urandom_range(0, 1) != 0) ? 4095 : 0;
         end else if (roll < 10) begin
            v[c] = $urandom_range(0, 4095);
         end else begin
            v[c] = level[c] + $urandom_range(0, 2 * spread) - spread;
            if (v[c] < 0) v[c] = 0;
            if (v[c] > 4095) v[c] = 4095;
         end
      end
      p.nh3_reading = 12'(v[0]);
      p.red_reading = 12'(v[1]);
      p.ox_reading  = 12'(v[2]);
      return p;
   endfunction

   // Offers one request after a random gap and records its prediction once taken.
   task automatic send_readings(req_payload_type p);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = p;
      do @(posedge clock); while (!req_ready);
      predicted_averages_q.push_back(predict_averages(p));
   endtask

   task automatic drop_request();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Register writes happen only once every response has been delivered.
   task automatic write_register(logic [CSR_INDEX_BITS-1:0] idx,
                                 logic [CSR_DATA_BITS-1:0] data);
      drop_request();
      while (predicted_averages_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WINDOW_LEN) begin
         window_len_reg = data[LEN_BITS-1:0];
         clear_windows();
      end else if (idx == CSR_THRESHOLD) begin
         threshold_reg = data;
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Receiver: a random stall before each response, or a long hold-off on request.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 5);
         if (long_hold > 0) begin
            stall     = long_hold;
            long_hold = 0;
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_ready = 1'b0;
         end
         @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Response checker: each response against the oldest prediction.
   always @(posedge clock) begin : check_response
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_averages_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Unexpected response %h at cycle %0d", rsp_payload, cycle_count);
         end else begin
            want = predicted_averages_q.pop_front();
            if (want.nh3_average !== rsp_payload.nh3_average ||
                want.red_average !== rsp_payload.red_average ||
                want.ox_average  !== rsp_payload.ox_average  ||
                want.nh3_settled !== rsp_payload.nh3_settled ||
                want.red_settled !== rsp_payload.red_settled ||
                want.ox_settled  !== rsp_payload.ox_settled  ||
                want.all_settled !== rsp_payload.all_settled) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("Mismatch at cycle %0d: avg exp %0d %0d %0d got %0d %0d %0d, %s",
                           cycle_count, want.nh3_average, want.red_average,
                           want.ox_average, rsp_payload.nh3_average,
                           rsp_payload.red_average, rsp_payload.ox_average,
                           $sformatf("flags exp %b%b%b%b got %b%b%b%b",
                                     want.nh3_settled, want.red_settled,
                                     want.ox_settled, want.all_settled,
                                     rsp_payload.nh3_settled, rsp_payload.red_settled,
                                     rsp_payload.ox_settled, rsp_payload.all_settled));
            end
         end
      end
   end

   // Reset values: window of ten, threshold four; extremes of the readings.
   task automatic test_default_settings();
      send_readings('{12'd0, 12'd0, 12'd0});
      send_readings('{12'd4095, 12'd4095, 12'd4095});
      send_readings('{12'd4095, 12'd0, 12'd2048});
      send_readings('{12'hAAA, 12'h555, 12'h001});
   endtask

   // A one-entry window settles at once; a zero threshold never settles.
   task automatic test_single_entry_window();
      write_register(CSR_WINDOW_LEN, 8'd1);
      send_readings('{12'd4095, 12'd0, 12'd1234});
      send_readings('{12'd7, 12'd4095, 12'd1234});
      send_readings('{12'd0, 12'd4095, 12'd1});
      write_register(CSR_THRESHOLD, 8'd0);
      send_readings('{12'd100, 12'd100, 12'd100});
      send_readings('{12'd100, 12'd100, 12'd100});
   endtask

   // A window length of zero behaves as a window of one entry.
   task automatic test_zero_length();
      write_register(CSR_THRESHOLD, 8'd4);
      write_register(CSR_WINDOW_LEN, 8'd0);
      send_readings('{12'd3000, 12'd5, 12'd4095});
      send_readings('{12'd3001, 12'd4000, 12'd0});
   endtask

   // Lengths beyond the maximum saturate; upper data bits are dropped.
   task automatic test_saturated_length();
      write_register(CSR_WINDOW_LEN, 8'hFF);
      write_register(CSR_THRESHOLD, 8'd255);
      send_readings('{12'd4095, 12'd4095, 12'd0});
      send_readings('{12'd4095, 12'd0, 12'd4095});
      send_readings('{12'd0, 12'd4095, 12'd4095});
      send_readings('{12'd300, 12'd250, 12'd200});
   endtask

   // Writes to unimplemented indexes must leave both registers untouched.
   task automatic test_ignored_index();
      write_register(CSR_UNUSED_LOW, 8'h55);
      write_register(CSR_UNUSED_HIGH, 8'hAA);
      send_readings('{12'd512, 12'd1024, 12'd2047});
      send_readings('{12'd512, 12'd1024, 12'd2047});
   endtask

   // Random phases, each with fresh register settings and moving sensor levels.
   task automatic test_random_readings();
      int roll;
      logic [LEN_BITS-1:0] len;
      logic [THR_BITS-1:0] thr;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)       len = 5'd0;
         else if (roll < 16) len = 5'($urandom_range(17, 31));
         else if (roll < 30) len = 5'd16;
         else                len = 5'($urandom_range(1, 16));
         roll = $urandom_range(0, 99);
         if (roll < 8)       thr = 8'd0;
         else if (roll < 16) thr = 8'($urandom_range(0, 255));
         else                thr = 8'($urandom_range(1, 16));
         write_register(CSR_WINDOW_LEN, {3'($urandom_range(0, 7)), len});
         write_register(CSR_THRESHOLD, thr);
         spread = $urandom_range(0, 12);
         for (int c = 0; c < NUM_CH; c++) level[c] = $urandom_range(0, 4095);
         steady_flow = (ph == RANDOM_PHASES / 2);
         for (int i = 0; i < PHASE_ITEMS; i++) send_readings(draw_readings());
         steady_flow = 1'b0;
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the block fills and has to stall its input.
   task automatic test_output_backpressure();
      write_register(CSR_WINDOW_LEN, 8'd4);
      write_register(CSR_THRESHOLD, 8'd6);
      spread      = 3;
      steady_flow = 1'b1;
      long_hold   = LONG_HOLD;
      for (int i = 0; i < 15; i++) send_readings(draw_readings());
      steady_flow = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      mismatches  = 0;
      cycle_count = 0;
      steady_flow = 1'b0;
      long_hold   = 0;
      spread      = 4;
      for (int c = 0; c < NUM_CH; c++) level[c] = 2048;
      window_len_reg = WINDOW_LEN_RESET;
      threshold_reg  = THRESHOLD_RESET;
      clear_windows();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_settings();
      test_single_entry_window();
      test_zero_length();
      test_saturated_length();
      test_ignored_index();
      test_random_readings();
      test_output_backpressure();

      // Let every outstanding response drain, then a little more.
      drop_request();
      while (predicted_averages_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES * 2) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/stab_pkg.sv
hw/rtl/stab_div.sv
hw/rtl/stab_ctrl.sv
hw/rtl/stab_dp.sv
hw/rtl/three_channel_stability_detector_top.sv
hw/rtl/stab_checker.sv
tb/three_channel_stability_detector_top_tb.sv
